// File: rtl/wsw_pkg.sv
// ----------------------------------------------------------------------------
// wsw_pkg
// Shared widths, reset values, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wsw_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int INTERVAL_W  = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [SAMPLE_W-1:0]   SPREAD_RESET   = 24'd240;
  localparam logic [COUNT_W-1:0]    HOLD_RESET     = 8'd4;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd300;
  localparam logic [COUNT_W-1:0]    COUNT_MAX      = 8'd255;

  localparam logic [CFG_INDEX_W-1:0] REG_SPREAD   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_CHECK,
    S_DIV,
    S_DONE
  } wsw_state_t;

  typedef struct packed {
    logic latch;
    logic decide;
    logic scan_run;
    logic check;
    logic div_run;
    logic out_load;
  } wsw_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic out_free;
  } wsw_stat_t;

endpackage

// File: rtl/weight_stability_window.sv
// ----------------------------------------------------------------------------
// weight_stability_window
// Moving-window weight averaging and stability detection for load-cell samples.
// ----------------------------------------------------------------------------
// Each input item either offers a weight sample with its millisecond timestamp
// or clears the window, and yields exactly one result item. An item occupies
// the block from its acceptance until its result is in the output register,
// waiting for that register to come free: the window memory is read one
// entry per cycle to form the sum, minimum and maximum, and the mean then
// comes from a restoring divider that yields one quotient bit per cycle. The
// next item is taken as soon as the result is in the output register, even
// if that result has not yet been taken downstream. Neither the input nor the
// configuration channel is ready during reset. Configuration writes are
// otherwise always ready and are meant to be made while no item is in flight.
// ----------------------------------------------------------------------------
module weight_stability_window
  import wsw_pkg::*;
#(
  parameter int WINDOW_SIZE = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // weight_sample[23:0], time_ms[55:24]
  input  logic                   in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // accepted[0], window_full[1],
                                             // average_weight[25:2],
                                             // stable_count[33:26], is_stable[34]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  wsw_cmd_t  cmd;
  wsw_stat_t stat;

  assign cfg_ready = rst_n;

  wsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wsw_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_cmd     (in_tuser),
    .in_weight  (in_tdata[SAMPLE_W-1:0]),
    .in_time    (in_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/wsw_dp.sv
// ----------------------------------------------------------------------------
// wsw_dp
// Datapath: configuration registers, sample window memory, window scan for
// sum, minimum and maximum, hold counter, bit-serial divider and output
// register.
// ----------------------------------------------------------------------------
module wsw_dp
  import wsw_pkg::*;
#(
  parameter int WINDOW_SIZE = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsw_cmd_t                    cmd,
  output wsw_stat_t                   stat,
  input  logic                        cfg_valid,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_cmd,
  input  logic signed [SAMPLE_W-1:0]  in_weight,
  input  logic [TIME_W-1:0]           in_time,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int IDX_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int PAD_W  = OUT_TDATA_W - (3 + SAMPLE_W + COUNT_W);
  localparam logic [CNT_W-1:0]  WIN_N    = CNT_W'(WINDOW_SIZE);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WINDOW_SIZE - 1);
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(SUM_W);

  // configuration
  logic [SAMPLE_W-1:0]   spread_thr_r;
  logic [COUNT_W-1:0]    hold_req_r;
  logic [INTERVAL_W-1:0] interval_r;

  // latched item
  logic                       cmd_r;
  logic signed [SAMPLE_W-1:0] weight_r;
  logic [TIME_W-1:0]          time_r;

  // window state
  logic signed [SAMPLE_W-1:0] window_mem [WINDOW_SIZE];
  logic [IDX_W-1:0]           wr_idx_r;
  logic                       full_r;
  logic [COUNT_W-1:0]         hold_cnt_r;
  logic [TIME_W-1:0]          last_time_r;
  logic                       stored_r;

  // scan
  logic [CNT_W-1:0]           scan_addr_r;
  logic                       rd_vld_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       first_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;

  // divider
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              neg_r;

  // output
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [TIME_W-1:0]        elapsed;
  logic                     do_store;
  logic [CNT_W-1:0]         n_fill;
  logic                     scan_more;
  logic                     scan_issue;
  logic [SAMPLE_W:0]        spread;
  logic                     spread_ok;
  logic [SUM_W-1:0]         sum_abs;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;
  logic [SAMPLE_W-1:0]      quo_low;
  logic [SAMPLE_W-1:0]      avg;
  logic                     is_stable;

  assign elapsed    = time_r - last_time_r;
  assign do_store   = !cmd_r && (elapsed >= TIME_W'(interval_r));
  assign n_fill     = full_r ? WIN_N : CNT_W'(wr_idx_r);
  assign scan_more  = scan_addr_r < n_fill;
  assign scan_issue = cmd.scan_run && scan_more;
  assign spread     = {max_r[SAMPLE_W-1], max_r} - {min_r[SAMPLE_W-1], min_r};
  assign spread_ok  = spread < {1'b0, spread_thr_r};
  assign sum_abs    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign trial      = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge   = trial >= {1'b0, n_fill};
  assign quo_low    = quo_r[SAMPLE_W-1:0];
  assign avg        = (n_fill == '0) ? '0 : (neg_r ? (-quo_low) : quo_low);
  assign is_stable  = hold_cnt_r >= hold_req_r;

  assign stat.scan_done = !scan_more && !rd_vld_r;
  assign stat.div_done  = (dcnt_r == '0);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_thr_r <= SPREAD_RESET;
      hold_req_r   <= HOLD_RESET;
      interval_r   <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPREAD:   spread_thr_r <= cfg_data;
        REG_HOLD:     hold_req_r   <= cfg_data[COUNT_W-1:0];
        REG_INTERVAL: interval_r   <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r    <= in_cmd;
      weight_r <= in_weight;
      time_r   <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      full_r      <= 1'b0;
      hold_cnt_r  <= '0;
      last_time_r <= '0;
      stored_r    <= 1'b0;
    end else if (cmd.decide) begin
      if (cmd_r) begin
        wr_idx_r   <= '0;
        full_r     <= 1'b0;
        hold_cnt_r <= '0;
        stored_r   <= 1'b0;
      end else if (do_store) begin
        stored_r    <= 1'b1;
        last_time_r <= time_r;
        if (wr_idx_r == IDX_LAST) begin
          wr_idx_r <= '0;
          full_r   <= 1'b1;
        end else begin
          wr_idx_r <= wr_idx_r + 1'b1;
        end
      end else begin
        stored_r <= 1'b0;
      end
    end else if (cmd.check && stored_r) begin
      if (!full_r || !spread_ok) begin
        hold_cnt_r <= '0;
      end else if (hold_cnt_r != COUNT_MAX) begin
        hold_cnt_r <= hold_cnt_r + 1'b1;
      end
    end
  end

  // window memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.decide && do_store) begin
      window_mem[wr_idx_r] <= weight_r;
    end
    if (scan_issue) begin
      rd_data_r <= window_mem[scan_addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else if (cmd.decide) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_vld_r <= scan_more;
      if (scan_more) begin
        scan_addr_r <= scan_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      sum_r   <= '0;
      first_r <= 1'b1;
    end else if (cmd.scan_run && rd_vld_r) begin
      sum_r   <= sum_r + SUM_W'(rd_data_r);
      first_r <= 1'b0;
      if (first_r || (rd_data_r < min_r)) begin
        min_r <= rd_data_r;
      end
      if (first_r || (rd_data_r > max_r)) begin
        max_r <= rd_data_r;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.check) begin
      dcnt_r <= DIV_STEPS;
    end else if (cmd.div_run && (dcnt_r != '0)) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      quo_r <= sum_abs;
      rem_r <= '0;
      neg_r <= sum_r[SUM_W-1];
    end else if (cmd.div_run && (dcnt_r != '0)) begin
      quo_r <= {quo_r[SUM_W-2:0], trial_ge};
      if (trial_ge) begin
        rem_r <= CNT_W'(trial - {1'b0, n_fill});
      end else begin
        rem_r <= trial[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {{PAD_W{1'b0}}, is_stable, hold_cnt_r, avg, full_r, stored_r};
    end
  end

endmodule

// File: rtl/wsw_ctrl.sv
// ----------------------------------------------------------------------------
// wsw_ctrl
// Controller: steps one item through decide, window scan, stability check,
// division and hand-over to the output register.
// ----------------------------------------------------------------------------
module wsw_ctrl
  import wsw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  wsw_stat_t stat,
  output wsw_cmd_t  cmd
);

  wsw_state_t state_r;
  wsw_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: tb/wsw_result_check.sv
// ----------------------------------------------------------------------------
// wsw_result_check
// Watches the input, result and register channels of the weight stability
// window. It keeps its own copy of the sample window, hold counter and
// registers, works out the result due for every accepted input item, and
// compares each accepted result item field by field with the oldest one due.
// Failures and the number of results still due are handed to the top.
// ----------------------------------------------------------------------------
module wsw_result_check
  import wsw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // weight_sample[23:0], time_ms[55:24]
  input  logic                   in_tuser,   // cmd
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // accepted[0], window_full[1],
                                             // average_weight[25:2],
                                             // stable_count[33:26], is_stable[34]
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int DEPTH = 8;

  typedef struct packed {
    logic                       is_stable;
    logic [COUNT_W-1:0]         stable_count;
    logic signed [SAMPLE_W-1:0] average_weight;
    logic                       window_full;
    logic                       accepted;
  } weigh_result_t;

  logic signed [SAMPLE_W-1:0] window_q [DEPTH];
  logic [2:0]                 slot;
  logic                       wrapped;
  logic [COUNT_W-1:0]         run_len;
  logic [TIME_W-1:0]          stored_at;
  logic [SAMPLE_W-1:0]        spread_lim;
  logic [COUNT_W-1:0]         hold_need;
  logic [INTERVAL_W-1:0]      gap_ms;

  weigh_result_t due_results [$];
  int            fails = 0;

  task automatic clear_window();
    for (int i = 0; i < DEPTH; i++) window_q[i] = '0;
    slot = '0;
    wrapped = 1'b0;
    run_len = '0;
  endtask

  task automatic weigh_item(input logic cmd, input logic signed [SAMPLE_W-1:0] w,
                            input logic [TIME_W-1:0] t, output weigh_result_t res);
    logic [TIME_W-1:0] elapsed;
    int                lo;
    int                hi;
    int                n;
    longint            sum;
    res = '0;
    elapsed = t - stored_at;
    if (cmd) begin
      clear_window();
    end else if (elapsed >= TIME_W'(gap_ms)) begin
      res.accepted = 1'b1;
      stored_at = t;
      window_q[slot] = w;
      // three-bit index wraps at the window depth of eight
      slot = slot + 3'd1;
      if (slot == 3'd0) wrapped = 1'b1;
      if (!wrapped) begin
        run_len = '0;
      end else begin
        lo = window_q[0];
        hi = window_q[0];
        for (int i = 1; i < DEPTH; i++) begin
          if (window_q[i] < lo) lo = window_q[i];
          if (window_q[i] > hi) hi = window_q[i];
        end
        if (hi - lo < int'(spread_lim)) begin
          if (run_len != COUNT_MAX) run_len = run_len + 1'b1;
        end else begin
          run_len = '0;
        end
      end
    end
    n = wrapped ? DEPTH : int'(slot);
    sum = 0;
    for (int i = 0; i < n; i++) sum += window_q[i];
    res.average_weight = (n == 0) ? '0 : SAMPLE_W'(sum / n);
    res.window_full = wrapped;
    res.stable_count = run_len;
    res.is_stable = (run_len >= hold_need);
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    weigh_result_t want;
    if (!rst_n) begin
      clear_window();
      stored_at = '0;
      spread_lim = SPREAD_RESET;
      hold_need = HOLD_RESET;
      gap_ms = INTERVAL_RESET;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result item with nothing due: %h", out_tdata);
          fails++;
        end else begin
          want = due_results.pop_front();
          compare_field("accepted", want.accepted, out_tdata[0]);
          compare_field("window_full", want.window_full, out_tdata[1]);
          compare_field("average_weight", $signed(want.average_weight),
                        $signed(out_tdata[25:2]));
          compare_field("stable_count", want.stable_count, out_tdata[33:26]);
          compare_field("is_stable", want.is_stable, out_tdata[34]);
          compare_field("padding", 0, out_tdata[OUT_TDATA_W-1:35]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPREAD:   spread_lim = cfg_data[SAMPLE_W-1:0];
          REG_HOLD:     hold_need = cfg_data[COUNT_W-1:0];
          REG_INTERVAL: gap_ms = cfg_data[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        weigh_item(in_tuser, in_tdata[SAMPLE_W-1:0], in_tdata[SAMPLE_W +: TIME_W], want);
        due_results.push_back(want);
      end
    end
    mismatches <= fails;
    outstanding <= due_results.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the weight stability window. A short directed run covers
// the startup refusal, field extremes, clear, window fill, stable hold, a
// spread reset and timestamp wrap; random phases then sweep the registers
// through their extremes with jittery weight runs, refused offers, clears and
// noise, under random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import wsw_pkg::*;

  localparam int RUN_LIMIT = 8_000_000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int                     mismatches;
  int                     outstanding;
  bit                     no_idle = 1'b0;
  bit                     long_hold_req = 1'b0;
  logic [INTERVAL_W-1:0]  cur_gap = INTERVAL_RESET;
  logic [TIME_W-1:0]      t_base = '0;

  weight_stability_window #(.WINDOW_SIZE(8)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wsw_result_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #RUN_LIMIT;
    $display("weight_stability_window regression: fail");
    $finish;
  end

  // result side: random stalls, one long hold-off
  initial begin : sink
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] w,
                           input logic [TIME_W-1:0] t);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {t, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] spread,
                           input logic [CFG_DATA_W-1:0] hold_word,
                           input logic [CFG_DATA_W-1:0] gap_word);
    write_reg(REG_SPREAD, spread);
    write_reg(REG_HOLD, hold_word);
    write_reg(REG_INTERVAL, gap_word);
    cfg_valid <= 1'b0;
    cur_gap = gap_word[INTERVAL_W-1:0];
  endtask

  // mostly well-timed offers around a drifting base weight
  task automatic run_phase(input int n, input int clear_pct, input int noise_pct,
                           input int jitter);
    int                base;
    int                w;
    int                r;
    logic [TIME_W-1:0] t;
    base = int'($urandom_range(0, 8000000)) - 4000000;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < clear_pct) begin
        send_item(CMD_CLEAR, SAMPLE_W'($urandom), $urandom);
      end else begin
        if ($urandom_range(0, 99) < 4) base = int'($urandom_range(0, 8000000)) - 4000000;
        if ($urandom_range(0, 99) < noise_pct) w = $urandom;
        else w = base + int'($urandom_range(0, 2 * jitter)) - jitter;
        r = $urandom_range(0, 99);
        if (r < 70 || cur_gap == 0) begin
          t = t_base + cur_gap + $urandom_range(0, 40);
          t_base = t;
        end else if (r < 92) begin
          t = t_base + $urandom_range(0, cur_gap - 1);
        end else begin
          t = $urandom;
          t_base = t;
        end
        send_item(CMD_SAMPLE, SAMPLE_W'(w), t);
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // startup refusal, then both weight extremes
    send_item(CMD_SAMPLE, 24'd0, 32'd0);
    send_item(CMD_SAMPLE, 24'd123, 32'd299);
    send_item(CMD_SAMPLE, 24'h7FFFFF, 32'd300);
    send_item(CMD_SAMPLE, 24'h800000, 32'd600);
    send_item(CMD_CLEAR, 24'hFFFFFF, 32'hFFFF_FFFF);
    // fill the window, then hold stable until reported
    for (int i = 0; i < 8; i++) send_item(CMD_SAMPLE, SAMPLE_W'(1000 + i), 32'(900 + 300 * i));
    send_item(CMD_SAMPLE, 24'd1003, 32'd3300);
    send_item(CMD_SAMPLE, 24'd1003, 32'd3600);
    send_item(CMD_SAMPLE, 24'd1003, 32'd3900);
    // wide spread breaks the run
    send_item(CMD_SAMPLE, 24'h800000, 32'd4200);
    send_item(CMD_SAMPLE, 24'd5, 32'd4499);
    // timestamp wrap
    send_item(CMD_SAMPLE, 24'd7, 32'hFFFF_FF00);
    send_item(CMD_SAMPLE, 24'd9, 32'h0000_0010);
    send_item(CMD_SAMPLE, 24'd11, 32'h0000_002C);
    send_item(CMD_CLEAR, 24'h000000, 32'h0000_0000);
    t_base = 32'h0000_002C;

    drain();
    configure(24'd240, 24'd4, 24'd300);
    long_hold_req = 1'b1;
    run_phase(130, 5, 8, 6);

    drain();
    configure(24'd0, 24'd1, 24'd0);
    run_phase(130, 5, 10, 3);

    // long stable run to saturate the hold counter
    drain();
    configure(24'hFFFFFF, 24'h5A5AFF, 24'h000000);
    run_phase(300, 0, 0, 1000);

    // zero hold requirement, widest interval, junk above register widths
    drain();
    configure(24'd50, 24'hC3A500, 24'h7FFFFF);
    run_phase(130, 6, 8, 30);

    drain();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    configure(CFG_DATA_W'($urandom_range(1, 5000)), CFG_DATA_W'($urandom_range(1, 12)),
              CFG_DATA_W'($urandom_range(1, 1000)));
    run_phase(130, 8, 10, $urandom_range(0, 3000));

    drain();
    configure(CFG_DATA_W'($urandom_range(1, 5000)), CFG_DATA_W'($urandom_range(1, 12)),
              CFG_DATA_W'($urandom_range(1, 1000)));
    t_base = 32'hFFFF_F000;
    run_phase(130, 8, 10, $urandom_range(0, 3000));

    drain();
    configure(SPREAD_RESET, HOLD_RESET, INTERVAL_RESET);
    no_idle = 1'b1;
    run_phase(130, 5, 8, 6);

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("weight_stability_window regression: pass");
    end else begin
      $display("weight_stability_window regression: fail");
    end
    $finish;
  end

endmodule
